### design/omdf_pkg.sv
package omdf_pkg;

  typedef struct packed {
    logic               starts_pass;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] vel_z;
    logic [62:0]        body_mass;
    logic [62:0]        tau_migration;
    logic [62:0]        tau_ecc;
  } omdf_in_t;

  typedef struct packed {
    logic signed [63:0] dacc_x;
    logic signed [63:0] dacc_y;
    logic signed [63:0] dacc_z;
    logic               math_fault;
  } omdf_out_t;

  // flop operands visible to the datapath
  typedef struct packed {
    logic [63:0] cpx, cpy, cpz, cvx, cvy, cvz, cmass, grav;
    logic [63:0] px, py, pz, vx, vy, vz, mass, taua, taue;
    logic [63:0] acx, acy, acz;
  } omdf_bank_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIVS, OP_DIVU, OP_SQRT, OP_TAU15,
    OP_SHL1, OP_MADD, OP_MOVZF, OP_JZ, OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] dst;
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [7:0] tgt;
  } uop_t;

  localparam logic [63:0] ONE_Q   = 64'h0000_0100_0000_0000;
  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN    = 64'h8000_0000_0000_0000;

  // scratch registers
  localparam logic [5:0] R_D0 = 6'd0,  R_D1 = 6'd1,  R_D2 = 6'd2;
  localparam logic [5:0] R_V0 = 6'd3,  R_V1 = 6'd4,  R_V2 = 6'd5;
  localparam logic [5:0] R_NM = 6'd6,  R_T0 = 6'd7,  R_T1 = 6'd8;
  localparam logic [5:0] R_TE = 6'd9,  R_MU = 6'd10;
  localparam logic [5:0] R_H0 = 6'd11, R_H1 = 6'd12, R_H2 = 6'd13;
  localparam logic [5:0] R_HM = 6'd14, R_VV = 6'd15, R_R = 6'd16;
  localparam logic [5:0] R_RV = 6'd17, R_MUR = 6'd18, R_K = 6'd19;
  localparam logic [5:0] R_E0 = 6'd20, R_E1 = 6'd21, R_E2 = 6'd22;
  localparam logic [5:0] R_MA = 6'd23, R_OM = 6'd24, R_P1 = 6'd25;
  localparam logic [5:0] R_P2 = 6'd26, R_RH = 6'd27;
  // flop operands
  localparam logic [5:0] A_CPX = 6'd32, A_CPY = 6'd33, A_CPZ = 6'd34;
  localparam logic [5:0] A_CVX = 6'd35, A_CVY = 6'd36, A_CVZ = 6'd37;
  localparam logic [5:0] A_CMASS = 6'd38, A_GRAV = 6'd39;
  localparam logic [5:0] A_PX = 6'd40, A_PY = 6'd41, A_PZ = 6'd42;
  localparam logic [5:0] A_VX = 6'd43, A_VY = 6'd44, A_VZ = 6'd45;
  localparam logic [5:0] A_MASS = 6'd46, A_TAUA = 6'd47, A_TAUE = 6'd48;
  localparam logic [5:0] A_ZERO = 6'd49, A_ONE = 6'd50;
  localparam logic [5:0] A_ACX = 6'd51, A_ACY = 6'd52, A_ACZ = 6'd53;

  localparam logic [7:0] L_DAMP = 8'd15;
  localparam logic [7:0] L_COM  = 8'd102;
  localparam logic [7:0] L_END  = 8'd127;

  function automatic logic [63:0] smag(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : MAG_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : MAG_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_mag(input logic [127:0] q, input logic neg);
    logic [63:0] lim;
    lim = neg ? SMIN : MAG_MAX;
    if (q[127:64] != 64'd0 || q[63:0] > lim) return neg ? SMIN : MAG_MAX;
    return neg ? (64'd0 - q[63:0]) : q[63:0];
  endfunction

  function automatic uop_t mk(input op_e op, input logic [5:0] d, input logic [5:0] a,
                              input logic [5:0] b, input logic [7:0] t);
    uop_t w;
    w.op = op; w.dst = d; w.src_a = a; w.src_b = b; w.tgt = t;
    return w;
  endfunction

  function automatic uop_t ucode(input logic [7:0] pc);
    uop_t w;
    case (pc)
      8'd0:   w = mk(OP_SUB,  R_D0, A_PX, A_CPX, 8'd0);
      8'd1:   w = mk(OP_SUB,  R_D1, A_PY, A_CPY, 8'd0);
      8'd2:   w = mk(OP_SUB,  R_D2, A_PZ, A_CPZ, 8'd0);
      8'd3:   w = mk(OP_SUB,  R_V0, A_VX, A_CVX, 8'd0);
      8'd4:   w = mk(OP_SUB,  R_V1, A_VY, A_CVY, 8'd0);
      8'd5:   w = mk(OP_SUB,  R_V2, A_VZ, A_CVZ, 8'd0);
      8'd6:   w = mk(OP_MADD, R_NM, A_CMASS, A_MASS, 8'd0);
      // migration drag
      8'd7:   w = mk(OP_JZ,   R_T0, A_TAUA, A_ZERO, L_DAMP);
      8'd8:   w = mk(OP_SHL1, R_T0, A_TAUA, A_ZERO, 8'd0);
      8'd9:   w = mk(OP_DIVU, R_T1, R_V0, R_T0, 8'd0);
      8'd10:  w = mk(OP_SUB,  A_ACX, A_ZERO, R_T1, 8'd0);
      8'd11:  w = mk(OP_DIVU, R_T1, R_V1, R_T0, 8'd0);
      8'd12:  w = mk(OP_SUB,  A_ACY, A_ZERO, R_T1, 8'd0);
      8'd13:  w = mk(OP_DIVU, R_T1, R_V2, R_T0, 8'd0);
      8'd14:  w = mk(OP_SUB,  A_ACZ, A_ZERO, R_T1, 8'd0);
      // eccentricity damping
      8'd15:  w = mk(OP_JZ,   R_T0, A_TAUE, A_ZERO, L_COM);
      8'd16:  w = mk(OP_TAU15, R_TE, A_TAUE, A_ZERO, 8'd0);
      8'd17:  w = mk(OP_MUL,  R_MU, A_GRAV, R_NM, 8'd0);
      8'd18:  w = mk(OP_MUL,  R_T0, R_D1, R_V2, 8'd0);
      8'd19:  w = mk(OP_MUL,  R_T1, R_D2, R_V1, 8'd0);
      8'd20:  w = mk(OP_SUB,  R_H0, R_T0, R_T1, 8'd0);
      8'd21:  w = mk(OP_MUL,  R_T0, R_D2, R_V0, 8'd0);
      8'd22:  w = mk(OP_MUL,  R_T1, R_D0, R_V2, 8'd0);
      8'd23:  w = mk(OP_SUB,  R_H1, R_T0, R_T1, 8'd0);
      8'd24:  w = mk(OP_MUL,  R_T0, R_D0, R_V1, 8'd0);
      8'd25:  w = mk(OP_MUL,  R_T1, R_D1, R_V0, 8'd0);
      8'd26:  w = mk(OP_SUB,  R_H2, R_T0, R_T1, 8'd0);
      8'd27:  w = mk(OP_MUL,  R_T0, R_H0, R_H0, 8'd0);
      8'd28:  w = mk(OP_MUL,  R_T1, R_H1, R_H1, 8'd0);
      8'd29:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd30:  w = mk(OP_MUL,  R_T1, R_H2, R_H2, 8'd0);
      8'd31:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd32:  w = mk(OP_SQRT, R_HM, R_T0, A_ZERO, 8'd0);
      8'd33:  w = mk(OP_MUL,  R_T0, R_V0, R_V0, 8'd0);
      8'd34:  w = mk(OP_MUL,  R_T1, R_V1, R_V1, 8'd0);
      8'd35:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd36:  w = mk(OP_MUL,  R_T1, R_V2, R_V2, 8'd0);
      8'd37:  w = mk(OP_ADD,  R_VV, R_T0, R_T1, 8'd0);
      8'd38:  w = mk(OP_MUL,  R_T0, R_D0, R_D0, 8'd0);
      8'd39:  w = mk(OP_MUL,  R_T1, R_D1, R_D1, 8'd0);
      8'd40:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd41:  w = mk(OP_MUL,  R_T1, R_D2, R_D2, 8'd0);
      8'd42:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd43:  w = mk(OP_SQRT, R_R, R_T0, A_ZERO, 8'd0);
      8'd44:  w = mk(OP_MUL,  R_T0, R_D0, R_V0, 8'd0);
      8'd45:  w = mk(OP_MUL,  R_T1, R_D1, R_V1, 8'd0);
      8'd46:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd47:  w = mk(OP_MUL,  R_T1, R_D2, R_V2, 8'd0);
      8'd48:  w = mk(OP_ADD,  R_RV, R_T0, R_T1, 8'd0);
      8'd49:  w = mk(OP_DIVS, R_MUR, R_MU, R_R, 8'd0);
      8'd50:  w = mk(OP_SUB,  R_K, R_VV, R_MUR, 8'd0);
      8'd51:  w = mk(OP_MUL,  R_T0, R_K, R_D0, 8'd0);
      8'd52:  w = mk(OP_MUL,  R_T1, R_RV, R_V0, 8'd0);
      8'd53:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd54:  w = mk(OP_DIVS, R_E0, R_T0, R_MU, 8'd0);
      8'd55:  w = mk(OP_MUL,  R_T0, R_K, R_D1, 8'd0);
      8'd56:  w = mk(OP_MUL,  R_T1, R_RV, R_V1, 8'd0);
      8'd57:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd58:  w = mk(OP_DIVS, R_E1, R_T0, R_MU, 8'd0);
      8'd59:  w = mk(OP_MUL,  R_T0, R_K, R_D2, 8'd0);
      8'd60:  w = mk(OP_MUL,  R_T1, R_RV, R_V2, 8'd0);
      8'd61:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd62:  w = mk(OP_DIVS, R_E2, R_T0, R_MU, 8'd0);
      8'd63:  w = mk(OP_MUL,  R_T0, R_E0, R_E0, 8'd0);
      8'd64:  w = mk(OP_MUL,  R_T1, R_E1, R_E1, 8'd0);
      8'd65:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd66:  w = mk(OP_MUL,  R_T1, R_E2, R_E2, 8'd0);
      8'd67:  w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd68:  w = mk(OP_ADD,  R_T1, R_MUR, R_MUR, 8'd0);
      8'd69:  w = mk(OP_SUB,  R_MA, R_T1, R_VV, 8'd0);
      8'd70:  w = mk(OP_SUB,  R_OM, A_ONE, R_T0, 8'd0);
      8'd71:  w = mk(OP_DIVS, R_T0, A_ONE, R_OM, 8'd0);
      8'd72:  w = mk(OP_DIVU, R_P1, R_T0, R_TE, 8'd0);
      8'd73:  w = mk(OP_MUL,  R_RH, R_R, R_HM, 8'd0);
      8'd74:  w = mk(OP_DIVS, R_T0, R_MA, R_OM, 8'd0);
      8'd75:  w = mk(OP_SQRT, R_T0, R_T0, A_ZERO, 8'd0);
      8'd76:  w = mk(OP_DIVS, R_T0, R_T0, R_RH, 8'd0);
      8'd77:  w = mk(OP_DIVU, R_P2, R_T0, R_TE, 8'd0);
      8'd78:  w = mk(OP_MUL,  R_T0, R_H1, R_D2, 8'd0);
      8'd79:  w = mk(OP_MUL,  R_T1, R_H2, R_D1, 8'd0);
      8'd80:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd81:  w = mk(OP_MUL,  R_T0, R_T0, R_P2, 8'd0);
      8'd82:  w = mk(OP_MUL,  R_T1, R_V0, R_P1, 8'd0);
      8'd83:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd84:  w = mk(OP_MOVZF, R_T0, R_T0, A_ZERO, 8'd0);
      8'd85:  w = mk(OP_ADD,  A_ACX, A_ACX, R_T0, 8'd0);
      8'd86:  w = mk(OP_MUL,  R_T0, R_H2, R_D0, 8'd0);
      8'd87:  w = mk(OP_MUL,  R_T1, R_H0, R_D2, 8'd0);
      8'd88:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd89:  w = mk(OP_MUL,  R_T0, R_T0, R_P2, 8'd0);
      8'd90:  w = mk(OP_MUL,  R_T1, R_V1, R_P1, 8'd0);
      8'd91:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd92:  w = mk(OP_MOVZF, R_T0, R_T0, A_ZERO, 8'd0);
      8'd93:  w = mk(OP_ADD,  A_ACY, A_ACY, R_T0, 8'd0);
      8'd94:  w = mk(OP_MUL,  R_T0, R_H0, R_D1, 8'd0);
      8'd95:  w = mk(OP_MUL,  R_T1, R_H1, R_D0, 8'd0);
      8'd96:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd97:  w = mk(OP_MUL,  R_T0, R_T0, R_P2, 8'd0);
      8'd98:  w = mk(OP_MUL,  R_T1, R_V2, R_P1, 8'd0);
      8'd99:  w = mk(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      8'd100: w = mk(OP_MOVZF, R_T0, R_T0, A_ZERO, 8'd0);
      8'd101: w = mk(OP_ADD,  A_ACZ, A_ACZ, R_T0, 8'd0);
      // center of mass update
      8'd102: w = mk(OP_JZ,   R_T0, R_NM, A_ZERO, L_END);
      8'd103: w = mk(OP_MUL,  R_T0, A_CPX, A_CMASS, 8'd0);
      8'd104: w = mk(OP_MUL,  R_T1, A_PX, A_MASS, 8'd0);
      8'd105: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd106: w = mk(OP_DIVU, A_CPX, R_T0, R_NM, 8'd0);
      8'd107: w = mk(OP_MUL,  R_T0, A_CPY, A_CMASS, 8'd0);
      8'd108: w = mk(OP_MUL,  R_T1, A_PY, A_MASS, 8'd0);
      8'd109: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd110: w = mk(OP_DIVU, A_CPY, R_T0, R_NM, 8'd0);
      8'd111: w = mk(OP_MUL,  R_T0, A_CPZ, A_CMASS, 8'd0);
      8'd112: w = mk(OP_MUL,  R_T1, A_PZ, A_MASS, 8'd0);
      8'd113: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd114: w = mk(OP_DIVU, A_CPZ, R_T0, R_NM, 8'd0);
      8'd115: w = mk(OP_MUL,  R_T0, A_CVX, A_CMASS, 8'd0);
      8'd116: w = mk(OP_MUL,  R_T1, A_VX, A_MASS, 8'd0);
      8'd117: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd118: w = mk(OP_DIVU, A_CVX, R_T0, R_NM, 8'd0);
      8'd119: w = mk(OP_MUL,  R_T0, A_CVY, A_CMASS, 8'd0);
      8'd120: w = mk(OP_MUL,  R_T1, A_VY, A_MASS, 8'd0);
      8'd121: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd122: w = mk(OP_DIVU, A_CVY, R_T0, R_NM, 8'd0);
      8'd123: w = mk(OP_MUL,  R_T0, A_CVZ, A_CMASS, 8'd0);
      8'd124: w = mk(OP_MUL,  R_T1, A_VZ, A_MASS, 8'd0);
      8'd125: w = mk(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      8'd126: w = mk(OP_DIVU, A_CVZ, R_T0, R_NM, 8'd0);
      8'd127: w = mk(OP_ADD,  A_CMASS, R_NM, A_ZERO, 8'd0);
      default: w = mk(OP_END, R_T0, A_ZERO, A_ZERO, 8'd0);
    endcase
    return w;
  endfunction

endpackage

### design/omdf_ram.sv
module omdf_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/orbital_migration_damping_force.sv
// throughput: one body at a time, set by the bit-serial divider (up to 18 quotients
//   per body) and the 32x32 multiplier
// reset: center of mass and mass sum clear to zero, grav_const returns to four pi
//   squared; scratch memory needs no clearing
module orbital_migration_damping_force
  import omdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [62:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  omdf_in_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output omdf_out_t   out_item_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_UFIN  = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]   state_q, state_d;
  logic [7:0]   pc_q, pc_d;
  logic [62:0]  grav_q;
  omdf_in_t     in_q;
  logic [63:0]  cpx_q, cpy_q, cpz_q, cvx_q, cvy_q, cvz_q, cmass_q;
  logic [63:0]  acx_q, acx_d, acy_q, acy_d, acz_q, acz_d;
  logic         fault_q, fault_d;
  logic [63:0]  opa_q, opa_d, opb_q, opb_d, res_q, res_d;
  logic [63:0]  mag_a_q, mag_a_d, mag_b_q, mag_b_d, rem_q, rem_d;
  logic [127:0] wk_q, wk_d;
  logic         neg_q, neg_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         out_vld_q, out_vld_d;
  omdf_out_t    out_q, out_d;
  logic [63:0]  rd_a, rd_b;
  uop_t         uop;
  omdf_bank_t   bank;
  logic         accept, fin_load, wb_com;

  // mul, div, sqrt and madd step signals
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] pp_sh;
  logic [63:0]  dsh;
  logic         dge;
  logic [63:0]  sq_r2, sq_tr;
  logic [64:0]  msum;

  assign uop        = ucode(pc_q);
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign fin_load   = (state_q == S_FIN) && (!out_vld_q || out_ready_i);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign wb_com      = (state_q == S_WB);

  omdf_ram #(.Width(64), .Depth(32)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wb_com && !uop.dst[5]),
    .waddr_i (uop.dst[4:0]),
    .wdata_i (res_q),
    .raddr_i (uop.src_a[4:0]),
    .rdata_o (rd_a)
  );

  omdf_ram #(.Width(64), .Depth(32)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wb_com && !uop.dst[5]),
    .waddr_i (uop.dst[4:0]),
    .wdata_i (res_q),
    .raddr_i (uop.src_b[4:0]),
    .rdata_o (rd_b)
  );

  function automatic logic [63:0] pick(input logic [5:0] code, input logic [63:0] rd,
                                       input omdf_bank_t bk);
    logic [63:0] v;
    v = 64'd0;
    if (!code[5]) begin
      v = rd;
    end else begin
      case (code)
        A_CPX:   v = bk.cpx;
        A_CPY:   v = bk.cpy;
        A_CPZ:   v = bk.cpz;
        A_CVX:   v = bk.cvx;
        A_CVY:   v = bk.cvy;
        A_CVZ:   v = bk.cvz;
        A_CMASS: v = bk.cmass;
        A_GRAV:  v = bk.grav;
        A_PX:    v = bk.px;
        A_PY:    v = bk.py;
        A_PZ:    v = bk.pz;
        A_VX:    v = bk.vx;
        A_VY:    v = bk.vy;
        A_VZ:    v = bk.vz;
        A_MASS:  v = bk.mass;
        A_TAUA:  v = bk.taua;
        A_TAUE:  v = bk.taue;
        A_ONE:   v = ONE_Q;
        A_ACX:   v = bk.acx;
        A_ACY:   v = bk.acy;
        A_ACZ:   v = bk.acz;
        default: v = 64'd0;
      endcase
    end
    return v;
  endfunction

  always_comb begin
    bank.cpx   = cpx_q;
    bank.cpy   = cpy_q;
    bank.cpz   = cpz_q;
    bank.cvx   = cvx_q;
    bank.cvy   = cvy_q;
    bank.cvz   = cvz_q;
    bank.cmass = cmass_q;
    bank.grav  = {1'b0, grav_q};
    bank.px    = in_q.pos_x;
    bank.py    = in_q.pos_y;
    bank.pz    = in_q.pos_z;
    bank.vx    = in_q.vel_x;
    bank.vy    = in_q.vel_y;
    bank.vz    = in_q.vel_z;
    bank.mass  = {1'b0, in_q.body_mass};
    bank.taua  = {1'b0, in_q.tau_migration};
    bank.taue  = {1'b0, in_q.tau_ecc};
    bank.acx   = acx_q;
    bank.acy   = acy_q;
    bank.acz   = acz_q;
  end

  // datapath step logic
  always_comb begin
    pa    = cnt_q[1] ? mag_a_q[63:32] : mag_a_q[31:0];
    pb    = cnt_q[0] ? mag_b_q[63:32] : mag_b_q[31:0];
    pp    = {32'd0, pa} * {32'd0, pb};
    psh   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
    pp_sh = {64'd0, pp} << {psh, 5'd0};
    dsh   = {rem_q[62:0], wk_q[127]};
    dge   = rem_q[63] || (dsh >= mag_b_q);
    sq_r2 = {rem_q[61:0], wk_q[127:126]};
    sq_tr = {mag_a_q[61:0], 2'b01};
    msum  = {1'b0, opa_q} + {1'b0, opb_q};
  end

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    res_d    = res_q;
    mag_a_d  = mag_a_q;
    mag_b_d  = mag_b_q;
    rem_d    = rem_q;
    wk_d     = wk_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    fault_d  = fault_q;
    acx_d    = acx_q;
    acy_d    = acy_q;
    acz_d    = acz_q;
    out_d    = out_q;
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          acx_d   = 64'd0;
          acy_d   = 64'd0;
          acz_d   = 64'd0;
          fault_d = 1'b0;
          pc_d    = 8'd0;
          state_d = in_item_i.starts_pass ? S_FIN : S_FETCH;
        end
      end
      S_FETCH: state_d = S_LOAD;
      S_LOAD: begin
        opa_d   = pick(uop.src_a, rd_a, bank);
        opb_d   = pick(uop.src_b, rd_b, bank);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WB;
        cnt_d   = 7'd0;
        rem_d   = 64'd0;
        case (uop.op)
          OP_ADD:   res_d = sadd(opa_q, opb_q);
          OP_SUB:   res_d = ssub(opa_q, opb_q);
          OP_TAU15: res_d = opa_q + {1'b0, opa_q[63:1]};
          OP_SHL1:  res_d = {opa_q[62:0], 1'b0};
          OP_MADD:  res_d = (msum > {1'b0, MAG_MAX}) ? MAG_MAX : msum[63:0];
          OP_MOVZF: res_d = fault_q ? 64'd0 : opa_q;
          OP_MUL: begin
            mag_a_d = smag(opa_q);
            mag_b_d = smag(opb_q);
            neg_d   = opa_q[63] ^ opb_q[63];
            wk_d    = 128'd0;
            state_d = S_MUL;
          end
          OP_DIVS, OP_DIVU: begin
            mag_b_d = (uop.op == OP_DIVS) ? smag(opb_q) : opb_q;
            neg_d   = opa_q[63] ^ ((uop.op == OP_DIVS) && opb_q[63]);
            wk_d    = {24'd0, smag(opa_q), 40'd0};
            if (opb_q == 64'd0) begin
              fault_d = 1'b1;
              res_d   = 64'd0;
            end else begin
              state_d = S_DIV;
            end
          end
          OP_SQRT: begin
            mag_a_d = 64'd0;
            wk_d    = {opa_q, 64'd0};
            if (opa_q[63]) begin
              fault_d = 1'b1;
              res_d   = 64'd0;
            end else begin
              state_d = S_SQRT;
            end
          end
          OP_JZ: begin
            pc_d    = (opa_q == 64'd0) ? uop.tgt : pc_q + 8'd1;
            state_d = S_FETCH;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_MUL: begin
        wk_d  = wk_q + pp_sh;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_UFIN;
        end
      end
      S_DIV: begin
        rem_d = dge ? (dsh - mag_b_q) : dsh;
        wk_d  = {wk_q[126:0], dge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          state_d = S_UFIN;
        end
      end
      S_SQRT: begin
        wk_d  = {wk_q[125:0], 2'b00};
        cnt_d = cnt_q + 7'd1;
        if (sq_r2 >= sq_tr) begin
          rem_d   = sq_r2 - sq_tr;
          mag_a_d = {mag_a_q[62:0], 1'b1};
        end else begin
          rem_d   = sq_r2;
          mag_a_d = {mag_a_q[62:0], 1'b0};
        end
        if (cnt_q == 7'd51) begin
          state_d = S_UFIN;
        end
      end
      S_UFIN: begin
        case (uop.op)
          OP_MUL:  res_d = sat_mag({40'd0, wk_q[127:40]}, neg_q);
          OP_SQRT: res_d = {12'd0, mag_a_q[51:0]};
          default: res_d = sat_mag(wk_q, neg_q);
        endcase
        state_d = S_WB;
      end
      S_WB: begin
        case (uop.dst)
          A_ACX:   acx_d = res_q;
          A_ACY:   acy_d = res_q;
          A_ACZ:   acz_d = res_q;
          default: ;
        endcase
        pc_d    = pc_q + 8'd1;
        state_d = S_FETCH;
      end
      S_FIN: begin
        if (fin_load) begin
          out_d.dacc_x     = acx_q;
          out_d.dacc_y     = acy_q;
          out_d.dacc_z     = acz_q;
          out_d.math_fault = fault_q;
          out_vld_d        = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= 8'd0;
      out_vld_q <= 1'b0;
      grav_q    <= 63'd43407671848853;
      cpx_q     <= 64'd0;
      cpy_q     <= 64'd0;
      cpz_q     <= 64'd0;
      cvx_q     <= 64'd0;
      cvy_q     <= 64'd0;
      cvz_q     <= 64'd0;
      cmass_q   <= 64'd0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        grav_q <= cfg_wdata_i;
      end
      if (accept && in_item_i.starts_pass) begin
        // central body replaces the center of mass
        cpx_q   <= in_item_i.pos_x;
        cpy_q   <= in_item_i.pos_y;
        cpz_q   <= in_item_i.pos_z;
        cvx_q   <= in_item_i.vel_x;
        cvy_q   <= in_item_i.vel_y;
        cvz_q   <= in_item_i.vel_z;
        cmass_q <= {1'b0, in_item_i.body_mass};
      end else if (wb_com) begin
        case (uop.dst)
          A_CPX:   cpx_q   <= res_q;
          A_CPY:   cpy_q   <= res_q;
          A_CPZ:   cpz_q   <= res_q;
          A_CVX:   cvx_q   <= res_q;
          A_CVY:   cvy_q   <= res_q;
          A_CVZ:   cvz_q   <= res_q;
          A_CMASS: cmass_q <= res_q;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    res_q   <= res_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    rem_q   <= rem_d;
    wk_q    <= wk_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    fault_q <= fault_d;
    acx_q   <= acx_d;
    acy_q   <= acy_d;
    acz_q   <= acz_d;
    out_q   <= out_d;
  end

endmodule
